FILE: rtl/core/ljd_pkg.sv
`default_nettype none
package ljd_pkg;

	localparam int MAX_WIDTH      = 8192;
	localparam int MAX_COMPONENTS = 4;
	localparam int NUM_TABLES     = 4;
	localparam int MAX_CODE_LEN   = 16;

	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_COUNT  = 2'd1;
	localparam logic [1:0] OP_SYMBOL = 2'd2;
	localparam logic [1:0] OP_START  = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_RST    = 2'd1;
	localparam logic [1:0] STAT_MARKER = 2'd2;
	localparam logic [1:0] STAT_CODE   = 2'd3;

	localparam logic [2:0] CFG_WIDTH     = 3'd0;
	localparam logic [2:0] CFG_HEIGHT    = 3'd1;
	localparam logic [2:0] CFG_COMPS     = 3'd2;
	localparam logic [2:0] CFG_PRED      = 3'd3;
	localparam logic [2:0] CFG_PRECISION = 3'd4;
	localparam logic [2:0] CFG_PT        = 3'd5;
	localparam logic [2:0] CFG_RST_ROWS  = 3'd6;
	localparam logic [2:0] CFG_MAP       = 3'd7;

	localparam logic [16:0] NO_CODES  = 17'h1FFFF;
	localparam logic [7:0]  BYTE_FF   = 8'hFF;
	localparam logic [7:0]  BYTE_00   = 8'h00;
	localparam logic [7:0]  RST_BASE  = 8'hD0;
	localparam logic [15:0] DIFF_MIN  = 16'h8000;
	localparam logic [26:0] CODE_CLAMP = 27'h1000000;

	typedef enum logic [1:0] {
		PH_CODE,
		PH_MAG,
		PH_RESTART,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DRV_RD,
		S_DRV_WR,
		S_BIT,
		S_CMP,
		S_SYM,
		S_UP_RD,
		S_SAMP,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [1:0]  component;
		logic        last_img;
		logic [1:0]  status;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/core/lossless_jpeg_sample_decoder_top.sv
// A data byte is decoded bit by bit through derived-table reads, symbol reads,
// upper-row reads and sample writes; results then wait in a hold register and an
// output register. Table loads: a count load runs 16 read/derive/write steps, while a
// symbol load and a scan start complete in the idle state.
// One transaction is in flight at a time. Reset (arst_n low) clears control state,
// table valid bits and config to defaults; sample and symbol memories are not cleared.
`default_nettype none
module lossless_jpeg_sample_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [1:0]  table_select,
	input  wire logic [7:0]  entry_index,
	input  wire logic [7:0]  byte_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      sample,
	output logic [1:0]       component,
	output logic             last_of_image,
	output logic             last_of_run,
	output logic [1:0]       status,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration
	logic [13:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  comps_q;
	logic [2:0]  pred_q;
	logic [4:0]  prec_q;
	logic [3:0]  pt_q;
	logic [15:0] rst_rows_q;
	logic [7:0]  map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 14'd1;
			height_q   <= 16'd1;
			comps_q    <= 3'd1;
			pred_q     <= 3'd1;
			prec_q     <= 5'd16;
			pt_q       <= 4'd0;
			rst_rows_q <= 16'd0;
			map_q      <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ljd_pkg::CFG_WIDTH:     width_q    <= cfg_data[13:0];
				ljd_pkg::CFG_HEIGHT:    height_q   <= cfg_data;
				ljd_pkg::CFG_COMPS:     comps_q    <= cfg_data[2:0];
				ljd_pkg::CFG_PRED:      pred_q     <= cfg_data[2:0];
				ljd_pkg::CFG_PRECISION: prec_q     <= cfg_data[4:0];
				ljd_pkg::CFG_PT:        pt_q       <= cfg_data[3:0];
				ljd_pkg::CFG_RST_ROWS:  rst_rows_q <= cfg_data;
				ljd_pkg::CFG_MAP:       map_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// memories
	logic [7:0]  cnt_mem [64];
	logic [41:0] drv_mem [64];
	logic [7:0]  sym_mem [1024];
	logic [15:0] up_mem  [32768];

	logic        cnt_we, drv_we, sym_we, up_we;
	logic [5:0]  cnt_waddr, cnt_raddr, drv_waddr, drv_raddr;
	logic [7:0]  cnt_wdata;
	logic [41:0] drv_wdata;
	logic [9:0]  sym_waddr, sym_raddr;
	logic [7:0]  sym_wdata;
	logic [14:0] up_addr;
	logic [15:0] up_wdata;
	logic        up_re, sym_re, drv_re, cnt_re;

	logic [7:0]  cnt_rd_q;
	logic [41:0] drv_rd_q;
	logic [7:0]  sym_rd_q;
	logic [15:0] up_rd_q;
	logic        cnt_rv_q, drv_rv_q;
	logic [63:0] cnt_vld_q, drv_vld_q;

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		if (cnt_re)
			cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (drv_we)
			drv_mem[drv_waddr] <= drv_wdata;
		if (drv_re)
			drv_rd_q <= drv_mem[drv_raddr];
	end

	always_ff @(posedge clk) begin
		if (sym_we)
			sym_mem[sym_waddr] <= sym_wdata;
		if (sym_re)
			sym_rd_q <= sym_mem[sym_raddr];
	end

	always_ff @(posedge clk) begin
		if (up_we)
			up_mem[up_addr] <= up_wdata;
		if (up_re)
			up_rd_q <= up_mem[up_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			drv_vld_q <= '0;
			cnt_rv_q  <= 1'b0;
			drv_rv_q  <= 1'b0;
		end else begin
			if (cnt_we)
				cnt_vld_q[cnt_waddr] <= 1'b1;
			if (drv_we)
				drv_vld_q[drv_waddr] <= 1'b1;
			if (cnt_re)
				cnt_rv_q <= cnt_vld_q[cnt_raddr];
			if (drv_re)
				drv_rv_q <= drv_vld_q[drv_raddr];
		end
	end

	// control state
	ljd_pkg::state_t  state_q, state_n;
	ljd_pkg::phase_t  phase_q, phase_n;
	logic [15:0] left_q [4];
	logic [15:0] diag_q [4];
	logic [15:0] left_n [4];
	logic [15:0] diag_n [4];
	logic [15:0] bb_q, bb_n;
	logic [4:0]  bc_q, bc_n;
	logic [16:0] pc_q, pc_n;
	logic [4:0]  len_q, len_n;
	logic        pff_q, pff_n;
	logic [12:0] col_q, col_n;
	logic [15:0] row_q, row_n;
	logic [1:0]  comp_q, comp_n;
	logic [15:0] rl_q, rl_n;
	logic [2:0]  rnum_q, rnum_n;
	logic [7:0]  byte_q, byte_n;
	logic [2:0]  idx_q, idx_n;
	logic [15:0] sd_q, sd_n;
	logic [1:0]  sst_q, sst_n;
	logic [1:0]  dt_q, dt_n;
	logic [3:0]  dl_q, dl_n;
	logic [26:0] code_q, code_n;
	logic [8:0]  dp_q, dp_n;
	ljd_pkg::result_t hold_q, hold_n, out_q, out_n;
	logic        hold_v_q, hold_v_n, out_v_q, out_v_n, out_lr_q, out_lr_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ljd_pkg::S_IDLE;
			phase_q  <= ljd_pkg::PH_CODE;
			for (int i = 0; i < 4; i++) begin
				left_q[i] <= '0;
				diag_q[i] <= '0;
			end
			bb_q     <= '0;
			bc_q     <= '0;
			pc_q     <= '0;
			len_q    <= '0;
			pff_q    <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			comp_q   <= '0;
			rl_q     <= '0;
			rnum_q   <= '0;
			idx_q    <= '0;
			dt_q     <= '0;
			dl_q     <= '0;
			code_q   <= '0;
			dp_q     <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_n;
			phase_q  <= phase_n;
			for (int i = 0; i < 4; i++) begin
				left_q[i] <= left_n[i];
				diag_q[i] <= diag_n[i];
			end
			bb_q     <= bb_n;
			bc_q     <= bc_n;
			pc_q     <= pc_n;
			len_q    <= len_n;
			pff_q    <= pff_n;
			col_q    <= col_n;
			row_q    <= row_n;
			comp_q   <= comp_n;
			rl_q     <= rl_n;
			rnum_q   <= rnum_n;
			idx_q    <= idx_n;
			dt_q     <= dt_n;
			dl_q     <= dl_n;
			code_q   <= code_n;
			dp_q     <= dp_n;
			hold_v_q <= hold_v_n;
			out_v_q  <= out_v_n;
		end
	end

	always_ff @(posedge clk) begin
		byte_q   <= byte_n;
		sd_q     <= sd_n;
		sst_q    <= sst_n;
		hold_q   <= hold_n;
		out_q    <= out_n;
		out_lr_q <= out_lr_n;
	end

	// combinational helpers
	logic [1:0]  tbl;
	logic [2:0]  eff_c;
	logic [13:0] eff_w;
	logic [15:0] eff_h;
	logic        bit_in;
	logic [16:0] d_last;
	logic [15:0] d_first;
	logic [8:0]  d_off;
	logic        match;
	logic [7:0]  sym_k;
	logic [15:0] mag_bb;
	logic [4:0]  mag_bc;
	logic [3:0]  mag_s;
	logic [15:0] mag_half, mag_mask, mag_d;
	logic [7:0]  dn;
	logic [26:0] dsum;
	logic        first_row;
	logic signed [18:0] lf, up, dg, pred;
	logic signed [6:0]  sh;
	logic [15:0] samp_val;
	logic [1:0]  nc;
	logic [12:0] ncol;
	logic [15:0] nrow;
	logic        last_img;
	logic        out_free, adv, push;

	always_comb begin
		unique case (comp_q)
			2'd0: tbl = map_q[1:0];
			2'd1: tbl = map_q[3:2];
			2'd2: tbl = map_q[5:4];
			default: tbl = map_q[7:6];
		endcase
		eff_c = (comps_q == 3'd0) ? 3'd1 : ((comps_q > 3'd4) ? 3'd4 : comps_q);
		eff_w = (width_q == 14'd0) ? 14'd1 :
			((width_q > 14'(ljd_pkg::MAX_WIDTH)) ? 14'(ljd_pkg::MAX_WIDTH) : width_q);
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
		bit_in = byte_q[idx_q];

		d_last  = drv_rv_q ? drv_rd_q[41:25] : ljd_pkg::NO_CODES;
		d_first = drv_rv_q ? drv_rd_q[24:9] : 16'd0;
		d_off   = drv_rv_q ? drv_rd_q[8:0] : 9'd0;
		match   = (d_last != ljd_pkg::NO_CODES) && (pc_q <= d_last);
		sym_k   = d_off[7:0] + pc_q[7:0] - d_first[7:0];

		mag_bb   = {bb_q[14:0], bit_in};
		mag_bc   = bc_q + 5'd1;
		mag_s    = (len_q[3:0] == 4'd0) ? 4'd1 : len_q[3:0];
		mag_half = 16'd1 << (mag_s - 4'd1);
		mag_mask = (16'd1 << mag_s) - 16'd1;
		mag_d    = (mag_bb < mag_half) ? (mag_bb - mag_mask) : mag_bb;

		dn   = cnt_rv_q ? cnt_rd_q : 8'd0;
		dsum = code_q + {19'd0, dn};

		first_row = (row_q == 16'd0) || ((rst_rows_q != 16'd0) && (rl_q == rst_rows_q));
		lf = $signed({3'd0, left_q[comp_q]});
		up = $signed({3'd0, up_rd_q});
		dg = $signed({3'd0, diag_q[comp_q]});
		sh = $signed({2'd0, prec_q}) - $signed({3'd0, pt_q}) - 7'sd1;
		if (first_row) begin
			if (col_q == 13'd0)
				pred = (sh >= 7'sd0 && sh < 7'sd16) ? (19'sd1 <<< sh[3:0]) : 19'sd0;
			else
				pred = lf;
		end else if (col_q == 13'd0) begin
			pred = up;
		end else begin
			case (pred_q)
				3'd0: pred = 19'sd0;
				3'd1: pred = lf;
				3'd2: pred = up;
				3'd3: pred = dg;
				3'd4: pred = lf + up - dg;
				3'd5: pred = lf + ((up - dg) >>> 1);
				3'd6: pred = up + ((lf - dg) >>> 1);
				default: pred = (lf + up) >>> 1;
			endcase
		end
		samp_val = pred[15:0] + sd_q;
		nc   = comp_q + 2'd1;
		ncol = col_q + 13'd1;
		nrow = row_q + 16'd1;
		out_free = !out_v_q || out_ready;
	end

	always_comb begin
		state_n  = state_q;
		phase_n  = phase_q;
		for (int i = 0; i < 4; i++) begin
			left_n[i] = left_q[i];
			diag_n[i] = diag_q[i];
		end
		bb_n     = bb_q;
		bc_n     = bc_q;
		pc_n     = pc_q;
		len_n    = len_q;
		pff_n    = pff_q;
		col_n    = col_q;
		row_n    = row_q;
		comp_n   = comp_q;
		rl_n     = rl_q;
		rnum_n   = rnum_q;
		byte_n   = byte_q;
		idx_n    = idx_q;
		sd_n     = sd_q;
		sst_n    = sst_q;
		dt_n     = dt_q;
		dl_n     = dl_q;
		code_n   = code_q;
		dp_n     = dp_q;
		hold_n   = hold_q;
		hold_v_n = hold_v_q;
		out_n    = out_q;
		out_lr_n = out_lr_q;
		out_v_n  = out_v_q && !out_ready;
		push     = 1'b0;
		adv      = 1'b0;
		last_img = 1'b0;
		in_ready = (state_q == ljd_pkg::S_IDLE);

		cnt_we    = 1'b0;
		cnt_waddr = {table_select, entry_index[3:0]};
		cnt_wdata = byte_value;
		cnt_re    = 1'b0;
		cnt_raddr = {dt_q, dl_q};
		drv_we    = 1'b0;
		drv_waddr = {dt_q, dl_q};
		drv_wdata = '0;
		drv_re    = 1'b0;
		drv_raddr = {tbl, len_q[3:0]};
		sym_we    = 1'b0;
		sym_waddr = {table_select, entry_index};
		sym_wdata = byte_value;
		sym_re    = 1'b0;
		sym_raddr = {tbl, sym_k};
		up_we     = 1'b0;
		up_re     = 1'b0;
		up_addr   = {col_q, comp_q};
		up_wdata  = samp_val;

		unique case (state_q)
			ljd_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (operation)
						ljd_pkg::OP_COUNT: begin
							if (entry_index < 8'd16) begin
								cnt_we  = 1'b1;
								dt_n    = table_select;
								dl_n    = 4'd0;
								code_n  = '0;
								dp_n    = '0;
								state_n = ljd_pkg::S_DRV_RD;
							end
						end
						ljd_pkg::OP_SYMBOL: sym_we = 1'b1;
						ljd_pkg::OP_START: begin
							for (int i = 0; i < 4; i++) begin
								left_n[i] = '0;
								diag_n[i] = '0;
							end
							bb_n    = '0;
							bc_n    = '0;
							col_n   = '0;
							row_n   = '0;
							comp_n  = '0;
							rl_n    = rst_rows_q;
							rnum_n  = '0;
							phase_n = ljd_pkg::PH_CODE;
							pc_n    = '0;
							len_n   = '0;
							pff_n   = 1'b0;
						end
						default: begin
							if (phase_q == ljd_pkg::PH_RESTART) begin
								if (pff_q) begin
									if (byte_value == ljd_pkg::BYTE_00) begin
										pff_n = 1'b0;
									end else if (byte_value != ljd_pkg::BYTE_FF) begin
										pff_n = 1'b0;
										if (byte_value != (ljd_pkg::RST_BASE + {5'd0, rnum_q})) begin
											hold_n   = '{16'd0, comp_q, 1'b0, ljd_pkg::STAT_RST};
											hold_v_n = 1'b1;
											state_n  = ljd_pkg::S_FLUSH;
										end
										rl_n    = rst_rows_q;
										rnum_n  = rnum_q + 3'd1;
										phase_n = ljd_pkg::PH_CODE;
										pc_n    = '0;
										len_n   = '0;
										bb_n    = '0;
										bc_n    = '0;
									end
								end else if (byte_value == ljd_pkg::BYTE_FF) begin
									pff_n = 1'b1;
								end
							end else if (phase_q != ljd_pkg::PH_DONE) begin
								if (pff_q) begin
									if (byte_value == ljd_pkg::BYTE_00) begin
										pff_n   = 1'b0;
										byte_n  = ljd_pkg::BYTE_FF;
										idx_n   = 3'd7;
										state_n = ljd_pkg::S_BIT;
									end else if (byte_value != ljd_pkg::BYTE_FF) begin
										pff_n    = 1'b0;
										hold_n   = '{16'd0, comp_q, 1'b0, ljd_pkg::STAT_MARKER};
										hold_v_n = 1'b1;
										state_n  = ljd_pkg::S_FLUSH;
									end
								end else if (byte_value == ljd_pkg::BYTE_FF) begin
									pff_n = 1'b1;
								end else begin
									byte_n  = byte_value;
									idx_n   = 3'd7;
									state_n = ljd_pkg::S_BIT;
								end
							end
						end
					endcase
				end
			end

			ljd_pkg::S_DRV_RD: begin
				cnt_re  = 1'b1;
				state_n = ljd_pkg::S_DRV_WR;
			end

			ljd_pkg::S_DRV_WR: begin
				drv_we = 1'b1;
				code_n = code_q;
				if (dn != 8'd0) begin
					drv_wdata = {
						((dsum - 27'd1) > 27'hFFFF) ? 17'h0FFFF : {1'b0, dsum[15:0] - 16'd1},
						(code_q > 27'hFFFF) ? 16'hFFFF : code_q[15:0],
						dp_q};
					code_n = dsum;
					dp_n   = dp_q + {1'b0, dn};
				end else begin
					drv_wdata = {ljd_pkg::NO_CODES, 16'd0, 9'd0};
				end
				if (code_n > ljd_pkg::CODE_CLAMP)
					code_n = ljd_pkg::CODE_CLAMP;
				code_n = {code_n[25:0], 1'b0};
				dl_n   = dl_q + 4'd1;
				state_n = (dl_q == 4'd15) ? ljd_pkg::S_IDLE : ljd_pkg::S_DRV_RD;
			end

			ljd_pkg::S_BIT: begin
				if (phase_q == ljd_pkg::PH_CODE) begin
					drv_re  = 1'b1;
					pc_n    = {pc_q[15:0], bit_in};
					len_n   = len_q + 5'd1;
					state_n = ljd_pkg::S_CMP;
				end else begin
					bb_n = mag_bb;
					bc_n = mag_bc;
					if (mag_bc >= {1'b0, len_q[3:0]}) begin
						sd_n    = mag_d;
						sst_n   = ljd_pkg::STAT_OK;
						bb_n    = '0;
						bc_n    = '0;
						len_n   = '0;
						pc_n    = '0;
						phase_n = ljd_pkg::PH_CODE;
						state_n = ljd_pkg::S_UP_RD;
					end else begin
						adv = 1'b1;
					end
				end
			end

			ljd_pkg::S_CMP: begin
				if (match) begin
					sym_re  = 1'b1;
					pc_n    = '0;
					len_n   = '0;
					state_n = ljd_pkg::S_SYM;
				end else if (len_q >= 5'(ljd_pkg::MAX_CODE_LEN)) begin
					pc_n    = '0;
					len_n   = '0;
					sd_n    = '0;
					sst_n   = ljd_pkg::STAT_CODE;
					state_n = ljd_pkg::S_UP_RD;
				end else begin
					adv = 1'b1;
				end
			end

			ljd_pkg::S_SYM: begin
				if (sym_rd_q == 8'd0) begin
					sd_n    = '0;
					sst_n   = ljd_pkg::STAT_OK;
					state_n = ljd_pkg::S_UP_RD;
				end else if (sym_rd_q == 8'd16) begin
					sd_n    = ljd_pkg::DIFF_MIN;
					sst_n   = ljd_pkg::STAT_OK;
					state_n = ljd_pkg::S_UP_RD;
				end else if (sym_rd_q > 8'd16) begin
					sd_n    = '0;
					sst_n   = ljd_pkg::STAT_CODE;
					state_n = ljd_pkg::S_UP_RD;
				end else begin
					len_n   = sym_rd_q[4:0];
					bb_n    = '0;
					bc_n    = '0;
					phase_n = ljd_pkg::PH_MAG;
					adv     = 1'b1;
				end
			end

			ljd_pkg::S_UP_RD: begin
				up_re   = 1'b1;
				state_n = ljd_pkg::S_SAMP;
			end

			ljd_pkg::S_SAMP: begin
				if (!hold_v_q || out_free) begin
					push   = hold_v_q;
					up_we  = 1'b1;
					diag_n[comp_q] = up_rd_q;
					left_n[comp_q] = samp_val;
					comp_n = nc;
					if (({1'b0, nc} >= eff_c) || nc == 2'd0) begin
						comp_n = '0;
						col_n  = ncol;
						if (({1'b0, ncol} >= eff_w) || ncol == 13'd0) begin
							col_n = '0;
							row_n = nrow;
							if ((nrow >= eff_h) || nrow == 16'd0) begin
								phase_n  = ljd_pkg::PH_DONE;
								last_img = 1'b1;
							end else if (rst_rows_q != 16'd0) begin
								rl_n = (rl_q != 16'd0) ? rl_q - 16'd1 : rl_q;
								if (rl_n == 16'd0)
									phase_n = ljd_pkg::PH_RESTART;
							end
						end
					end
					hold_n   = '{samp_val, comp_q, last_img, sst_q};
					hold_v_n = 1'b1;
					adv      = 1'b1;
				end
			end

			ljd_pkg::S_FLUSH: begin
				if (!hold_v_q) begin
					state_n = ljd_pkg::S_IDLE;
				end else if (out_free) begin
					out_n    = hold_q;
					out_lr_n = 1'b1;
					out_v_n  = 1'b1;
					hold_v_n = 1'b0;
					state_n  = ljd_pkg::S_IDLE;
				end
			end

			default: state_n = ljd_pkg::S_IDLE;
		endcase

		if (push) begin
			out_n    = hold_q;
			out_lr_n = 1'b0;
			out_v_n  = 1'b1;
		end

		if (adv) begin
			if (phase_n == ljd_pkg::PH_RESTART || phase_n == ljd_pkg::PH_DONE
					|| idx_q == 3'd0) begin
				state_n = ljd_pkg::S_FLUSH;
			end else begin
				idx_n   = idx_q - 3'd1;
				state_n = ljd_pkg::S_BIT;
			end
		end
	end

	assign out_valid     = out_v_q;
	assign sample        = out_q.sample;
	assign component     = out_q.component;
	assign last_of_image = out_q.last_img;
	assign last_of_run   = out_lr_q;
	assign status        = out_q.status;

endmodule
`default_nettype wire
